// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/zbts_pkg.sv -----
// ---------------------------------------------------------------------------
// zbts_pkg
// Operation codes, flag masks and step unit types for the block engine.
// ---------------------------------------------------------------------------
package zbts_pkg;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_EXEC    = 2'd2;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  localparam logic [7:0] FL_S  = 8'h80;
  localparam logic [7:0] FL_Z  = 8'h40;
  localparam logic [7:0] FL_H  = 8'h10;
  localparam logic [7:0] FL_PV = 8'h04;
  localparam logic [7:0] FL_N  = 8'h02;

  typedef struct packed {
    logic [15:0] hl;
    logic [15:0] de;
    logic [15:0] bc;
    logic [7:0]  acc;
    logic [7:0]  flags;
    logic [7:0]  mem_byte;
    logic        search;
    logic        decrement;
    logic        repeat_req;
  } step_in_t;

  typedef struct packed {
    logic [15:0] hl;
    logic [15:0] de;
    logic [15:0] bc;
    logic [7:0]  flags;
    logic        again;
  } step_out_t;

endpackage

// ----- sv/zbts_ram.sv -----
// ---------------------------------------------------------------------------
// zbts_ram
// Generic single-clock RAM, one write port and one registered read port.
// ---------------------------------------------------------------------------
module zbts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/zbts_alu.sv -----
// ---------------------------------------------------------------------------
// zbts_alu
// Shared step unit: one transfer or compare step of a block instruction.
// ---------------------------------------------------------------------------
module zbts_alu (
  input  zbts_pkg::step_in_t  step_in,
  output zbts_pkg::step_out_t step_out
);

  logic [15:0] delta;
  logic [15:0] bc_dec;
  logic [7:0]  diff;
  logic        half_borrow;
  logic        bc_live;
  logic [7:0]  fl_ld;
  logic [7:0]  fl_cp;

  always_comb begin
    delta       = step_in.decrement ? 16'hFFFF : 16'h0001;
    bc_dec      = step_in.bc - 16'h0001;
    bc_live     = (bc_dec != 16'h0000);
    diff        = step_in.acc - step_in.mem_byte;
    half_borrow = (step_in.acc[3:0] < step_in.mem_byte[3:0]);

    fl_ld = step_in.flags & ~(zbts_pkg::FL_H | zbts_pkg::FL_N | zbts_pkg::FL_PV);
    if (bc_live) begin
      fl_ld = fl_ld | zbts_pkg::FL_PV;
    end

    fl_cp = (step_in.flags & ~(zbts_pkg::FL_S | zbts_pkg::FL_Z | zbts_pkg::FL_H |
                               zbts_pkg::FL_PV)) | zbts_pkg::FL_N;
    if (diff == 8'h00) begin
      fl_cp = fl_cp | zbts_pkg::FL_Z;
    end
    if (diff[7]) begin
      fl_cp = fl_cp | zbts_pkg::FL_S;
    end
    if (half_borrow) begin
      fl_cp = fl_cp | zbts_pkg::FL_H;
    end
    if (bc_live) begin
      fl_cp = fl_cp | zbts_pkg::FL_PV;
    end

    step_out.hl    = step_in.hl + delta;
    step_out.de    = step_in.search ? step_in.de : step_in.de + delta;
    step_out.bc    = bc_dec;
    step_out.flags = step_in.search ? fl_cp : fl_ld;
    // A search also stops as soon as A matches the byte.
    step_out.again = step_in.repeat_req && bc_live &&
                     (!step_in.search || (diff != 8'h00));
  end

endmodule

// ----- sv/z80_block_transfer_search.sv -----
// ---------------------------------------------------------------------------
// z80_block_transfer_search
// LDI/LDD/LDIR/LDDR and CPI/CPD/CPIR/CPDR engine over a private byte memory.
// ---------------------------------------------------------------------------
// Channel  Handshake            Beat contents
// in_      start / busy         operation, address, data, HL, DE, BC, A, flags
// out_     out_valid (strobe)   HL, DE, BC, flags, read byte
//
// A write or unknown operation uses the simple state, a read the read and
// read-wait states, and an execute a fetch and a step state for each of N
// steps (N up to 65536 when BC starts at zero); the fetch state exists as
// the RAM read port is registered. The result appears in the cycle after
// the item's last state, while the next item may already be taken.
// Reset clears the sequencer and the strobe only; memory is not cleared.
// The receiver cannot stall: each result beat lasts exactly one cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module z80_block_transfer_search #(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [15:0] in_hl_in,
  input  logic [15:0] in_de_in,
  input  logic [15:0] in_bc_in,
  input  logic [7:0]  in_acc,
  input  logic [7:0]  in_flags_in,
  input  logic        in_search,
  input  logic        in_decrement,
  input  logic        in_repeat_req,
  output logic        out_valid,
  output logic [15:0] out_hl_out,
  output logic [15:0] out_de_out,
  output logic [15:0] out_bc_out,
  output logic [7:0]  out_flags_out,
  output logic [7:0]  out_read_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SIMPLE = 3'd1;
  localparam logic [2:0] S_RD     = 3'd2;
  localparam logic [2:0] S_RDW    = 3'd3;
  localparam logic [2:0] S_FETCH  = 3'd4;
  localparam logic [2:0] S_STEP   = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  wdata_r, wdata_nxt;
  logic [15:0] hl_r, hl_nxt;
  logic [15:0] de_r, de_nxt;
  logic [15:0] bc_r, bc_nxt;
  logic [7:0]  acc_r, acc_nxt;
  logic [7:0]  fl_r, fl_nxt;
  logic        srch_r, srch_nxt;
  logic        down_r, down_nxt;
  logic        rep_r, rep_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_hl_r, out_hl_nxt;
  logic [15:0] out_de_r, out_de_nxt;
  logic [15:0] out_bc_r, out_bc_nxt;
  logic [7:0]  out_fl_r, out_fl_nxt;
  logic [7:0]  out_rd_r, out_rd_nxt;

  logic                 accept;
  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_waddr;
  logic [7:0]           ram_wdata;
  logic [ADDR_BITS-1:0] ram_raddr;
  logic [7:0]           ram_rdata;
  logic                 out_regs_zero;

  zbts_pkg::step_in_t  step_in;
  zbts_pkg::step_out_t step_out;

  zbts_ram #(
    .WIDTH (8),
    .DEPTH (1 << ADDR_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  zbts_alu u_alu (
    .step_in  (step_in),
    .step_out (step_out)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    step_in.hl         = hl_r;
    step_in.de         = de_r;
    step_in.bc         = bc_r;
    step_in.acc        = acc_r;
    step_in.flags      = fl_r;
    step_in.mem_byte   = ram_rdata;
    step_in.search     = srch_r;
    step_in.decrement  = down_r;
    step_in.repeat_req = rep_r;
  end

  // Reads come from the byte address on a read, from HL otherwise.
  assign ram_raddr = (state_r == S_RD) ? addr_r[ADDR_BITS-1:0] : hl_r[ADDR_BITS-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = de_r[ADDR_BITS-1:0];
    ram_wdata = ram_rdata;
    if (state_r == S_SIMPLE) begin
      ram_we    = (op_r == zbts_pkg::OP_WRITE);
      ram_waddr = addr_r[ADDR_BITS-1:0];
      ram_wdata = wdata_r;
    end else if (state_r == S_STEP) begin
      ram_we    = !srch_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    addr_nxt      = addr_r;
    wdata_nxt     = wdata_r;
    hl_nxt        = hl_r;
    de_nxt        = de_r;
    bc_nxt        = bc_r;
    acc_nxt       = acc_r;
    fl_nxt        = fl_r;
    srch_nxt      = srch_r;
    down_nxt      = down_r;
    rep_nxt       = rep_r;
    out_valid_nxt = 1'b0;
    out_hl_nxt    = out_hl_r;
    out_de_nxt    = out_de_r;
    out_bc_nxt    = out_bc_r;
    out_fl_nxt    = out_fl_r;
    out_rd_nxt    = out_rd_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_operation;
          addr_nxt  = in_address;
          wdata_nxt = in_write_data;
          hl_nxt    = in_hl_in;
          de_nxt    = in_de_in;
          bc_nxt    = in_bc_in;
          acc_nxt   = in_acc;
          fl_nxt    = in_flags_in;
          srch_nxt  = in_search;
          down_nxt  = in_decrement;
          rep_nxt   = in_repeat_req;
          unique case (in_operation)
            zbts_pkg::OP_WRITE:   state_nxt = S_SIMPLE;
            zbts_pkg::OP_READ:    state_nxt = S_RD;
            zbts_pkg::OP_EXEC:    state_nxt = S_FETCH;
            zbts_pkg::OP_UNKNOWN: state_nxt = S_SIMPLE;
          endcase
        end
      end
      S_SIMPLE: begin
        out_valid_nxt = 1'b1;
        out_hl_nxt    = 16'h0000;
        out_de_nxt    = 16'h0000;
        out_bc_nxt    = 16'h0000;
        out_fl_nxt    = 8'h00;
        out_rd_nxt    = 8'h00;
        state_nxt     = S_IDLE;
      end
      S_RD: begin
        state_nxt = S_RDW;
      end
      S_RDW: begin
        out_valid_nxt = 1'b1;
        out_hl_nxt    = 16'h0000;
        out_de_nxt    = 16'h0000;
        out_bc_nxt    = 16'h0000;
        out_fl_nxt    = 8'h00;
        out_rd_nxt    = ram_rdata;
        state_nxt     = S_IDLE;
      end
      S_FETCH: begin
        state_nxt = S_STEP;
      end
      S_STEP: begin
        hl_nxt = step_out.hl;
        de_nxt = step_out.de;
        bc_nxt = step_out.bc;
        fl_nxt = step_out.flags;
        if (step_out.again) begin
          state_nxt = S_FETCH;
        end else begin
          out_valid_nxt = 1'b1;
          out_hl_nxt    = step_out.hl;
          out_de_nxt    = step_out.de;
          out_bc_nxt    = step_out.bc;
          out_fl_nxt    = step_out.flags;
          out_rd_nxt    = 8'h00;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    addr_r   <= addr_nxt;
    wdata_r  <= wdata_nxt;
    hl_r     <= hl_nxt;
    de_r     <= de_nxt;
    bc_r     <= bc_nxt;
    acc_r    <= acc_nxt;
    fl_r     <= fl_nxt;
    srch_r   <= srch_nxt;
    down_r   <= down_nxt;
    rep_r    <= rep_nxt;
    out_hl_r <= out_hl_nxt;
    out_de_r <= out_de_nxt;
    out_bc_r <= out_bc_nxt;
    out_fl_r <= out_fl_nxt;
    out_rd_r <= out_rd_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_hl_out    = out_hl_r;
  assign out_de_out    = out_de_r;
  assign out_bc_out    = out_bc_r;
  assign out_flags_out = out_fl_r;
  assign out_read_data = out_rd_r;

  assign out_regs_zero = (out_hl_out == 16'h0000) && (out_de_out == 16'h0000) &&
                         (out_bc_out == 16'h0000) && (out_flags_out == 8'h00);

  // A result beat only ever follows a cycle of work.
  `ASSERT_SAME(a_result_after_work, out_valid, $past(busy))
  // An accepted item always occupies the sequencer.
  `ASSERT_NEXT(a_accept_busy, accept, busy)
  // A result carries either a read byte or register values, never both.
  `ASSERT_SAME(a_result_kind, out_valid, (out_read_data == 8'h00) || out_regs_zero)
  // Memory is only written during a byte write or a transfer step.
  `ASSERT_SAME(a_write_source, ram_we, (state_r == S_SIMPLE) || ((state_r == S_STEP) && !srch_r))

endmodule
